// File: design/vtfd_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer package
// Payload types, frame constants and the closing status decision shared by
// the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vtfd_pkg;

  // Frame layout constants.
  localparam logic [7:0]  HASH_MARK      = 8'h23;
  localparam logic [16:0] BODY_START     = 17'd24;
  localparam logic [17:0] FRAME_OVERHEAD = 18'd25;
  localparam logic [16:0] POS_MAX        = 17'h1FFFF;

  // Position codes of the header fields.
  localparam logic [16:0] POS_START_HI = 17'd1;
  localparam logic [16:0] POS_MSG_ID   = 17'd2;
  localparam logic [16:0] POS_RESP     = 17'd3;
  localparam logic [16:0] POS_LEN_HI   = 17'd22;
  localparam logic [16:0] POS_LEN_LO   = 17'd23;

  // Output queue geometry.
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Closing status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_START_ERR = 2'd1,
    ST_CHECK_ERR = 2'd2,
    ST_LEN_ERR   = 2'd3
  } vtfd_status_e;

  // One received byte.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } vtfd_in_t;

  // One result item: a body byte or the closing status.
  typedef struct packed {
    logic        frame_done;
    logic [7:0]  body_byte;
    logic [7:0]  message_id;
    logic [7:0]  response_flag;
    logic [15:0] declared_length;
    logic [1:0]  frame_status;
  } vtfd_out_t;

  // Result pushes produced by one processed byte.
  typedef struct packed {
    logic body;
    logic status;
  } vtfd_push_t;

  // Status decision for a frame of length len_i, in order of precedence.
  function automatic vtfd_status_e frame_status_f(
    input logic [17:0] len_i,
    input logic        start_ok_i,
    input logic [7:0]  check_i,
    input logic [7:0]  xor_i,
    input logic [15:0] held_len_i
  );
    vtfd_status_e st;
    if (len_i < 18'd2 || !start_ok_i) begin
      st = ST_START_ERR;
    end else if (len_i < 18'd3) begin
      st = ST_LEN_ERR;
    end else if (check_i != xor_i) begin
      st = ST_CHECK_ERR;
    end else if (len_i < FRAME_OVERHEAD ||
                 (len_i - FRAME_OVERHEAD) != {2'b00, held_len_i}) begin
      st = ST_LEN_ERR;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

`default_nettype wire

// File: design/vtfd_core.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer core
// Input register and per-byte frame tracking: header capture, XOR check,
// early end detection and generation of body and status results.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfd_core
  import vtfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire vtfd_in_t   in_data_i,
  input  wire logic       space_ok_i,
  output vtfd_push_t      push_o,
  output vtfd_out_t       body_item_o,
  output vtfd_out_t       status_item_o
);

  // Input register.
  logic     in_valid_q;
  vtfd_in_t in_data_q;
  logic     proc;

  // Frame tracking state.
  logic [16:0] pos_q, pos_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  d0_q, d0_d;
  logic [7:0]  d1_q, d1_d;
  logic [7:0]  id_q, id_d;
  logic [7:0]  flag_q, flag_d;
  logic [15:0] len_q, len_d;
  logic        start_q, start_d;
  logic        closed_q, closed_d;

  // Header values including this byte's capture.
  logic [7:0]  id_n, flag_n;
  logic [15:0] len_n;
  logic        start_n;
  logic        early;
  logic [7:0]  xor_fin;
  logic [7:0]  b;
  logic        last;

  assign b    = in_data_q.rx_byte;
  assign last = in_data_q.buffer_end;

  // The held byte is processed once the queue has room for both results.
  assign proc       = in_valid_q && space_ok_i;
  assign in_stall_o = in_valid_q && !space_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // A start pair at position two or later closes the frame.
  assign early = (pos_q >= 17'd3) && (d0_q == HASH_MARK) && (b == HASH_MARK);

  // Header capture by position.
  always_comb begin
    id_n    = id_q;
    flag_n  = flag_q;
    len_n   = len_q;
    start_n = start_q;
    case (pos_q)
      POS_START_HI: start_n = (d0_q == HASH_MARK) && (b == HASH_MARK);
      POS_MSG_ID:   id_n    = b;
      POS_RESP:     flag_n  = b;
      POS_LEN_HI:   len_n   = {b, len_q[7:0]};
      POS_LEN_LO:   len_n   = {len_q[15:8], b};
      default:      ;
    endcase
  end

  // Check value over bytes two up to the one before the check byte.
  always_comb begin
    xor_fin = xor_q;
    if (pos_q >= 17'd4) xor_fin = xor_fin ^ d1_q;
    if (pos_q >= 17'd3) xor_fin = xor_fin ^ d0_q;
  end

  // Next state and result generation.
  always_comb begin
    pos_d    = pos_q;
    xor_d    = xor_q;
    d0_d     = d0_q;
    d1_d     = d1_q;
    id_d     = id_q;
    flag_d   = flag_q;
    len_d    = len_q;
    start_d  = start_q;
    closed_d = closed_q;
    push_o   = '0;

    body_item_o           = '0;
    body_item_o.body_byte = b;

    status_item_o                 = '0;
    status_item_o.frame_done      = 1'b1;
    status_item_o.message_id      = id_n;
    status_item_o.response_flag   = flag_n;
    status_item_o.declared_length = len_n;
    status_item_o.frame_status    = frame_status_f({1'b0, pos_q} + 18'd1, start_n, b,
                                                   xor_fin, len_n);

    if (proc) begin
      if (closed_q) begin
        // Remainder of a buffer after an early end is dropped.
        if (last) closed_d = 1'b0;
      end else if (early) begin
        push_o.status                 = 1'b1;
        status_item_o.message_id      = id_q;
        status_item_o.response_flag   = flag_q;
        status_item_o.declared_length = len_q;
        status_item_o.frame_status    = frame_status_f({1'b0, pos_q} - 18'd1, start_q,
                                                       d1_q, xor_q, len_q);
        if (!last) closed_d = 1'b1;
      end else begin
        id_d    = id_n;
        flag_d  = flag_n;
        len_d   = len_n;
        start_d = start_n;
        push_o.body = (pos_q >= BODY_START) && ((pos_q - BODY_START) < {1'b0, len_n});
        if (last) begin
          push_o.status = 1'b1;
        end else begin
          if (pos_q >= 17'd4) xor_d = xor_q ^ d1_q;
          d1_d = d0_q;
          d0_d = b;
          if (pos_q != POS_MAX) pos_d = pos_q + 17'd1;
        end
      end
      // The final byte of a buffer always returns the state to reset.
      if (last) begin
        pos_d    = '0;
        xor_d    = '0;
        d0_d     = '0;
        d1_d     = '0;
        id_d     = '0;
        flag_d   = '0;
        len_d    = '0;
        start_d  = 1'b0;
        closed_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      xor_q    <= '0;
      d0_q     <= '0;
      d1_q     <= '0;
      id_q     <= '0;
      flag_q   <= '0;
      len_q    <= '0;
      start_q  <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      xor_q    <= xor_d;
      d0_q     <= d0_d;
      d1_q     <= d1_d;
      id_q     <= id_d;
      flag_q   <= flag_d;
      len_q    <= len_d;
      start_q  <= start_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

// File: design/vtfd_outq.sv
// ----------------------------------------------------------------------------
// Telemetry frame deframer output queue
// Small result queue that takes up to two results a cycle and presents one
// registered result a cycle to the output channel when it does not stall.
// ----------------------------------------------------------------------------
`default_nettype none

module vtfd_outq
  import vtfd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire vtfd_push_t  push_i,
  input  wire vtfd_out_t   body_item_i,
  input  wire vtfd_out_t   status_item_i,
  output logic             space_ok_o,
  output logic [OQ_CW-1:0] level_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output vtfd_out_t        out_data_o
);

  vtfd_out_t          mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [OQ_CW-1:0]   cnt_q, cnt_d;
  logic [OQ_CW-1:0]   n_push;
  logic               pop;
  vtfd_out_t          first_item;
  logic [OQ_AW-1:0]   wr_next;

  assign n_push     = OQ_CW'(push_i.body) + OQ_CW'(push_i.status);
  assign pop        = out_valid_o && !out_stall_i;
  assign space_ok_o = cnt_q <= OQ_CW'(OQ_DEPTH - 2);
  assign level_o    = cnt_q;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_q];

  // The body byte precedes the status of the same input byte.
  assign first_item = push_i.body ? body_item_i : status_item_i;
  assign wr_next    = wr_q + OQ_AW'(1);

  always_comb begin
    wr_d  = wr_q + n_push[OQ_AW-1:0];
    rd_d  = pop ? rd_q + OQ_AW'(1) : rd_q;
    cnt_d = cnt_q + n_push - OQ_CW'(pop);
  end

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (n_push != '0) mem_q[wr_q] <= first_item;
    if (push_i.body && push_i.status) mem_q[wr_next] <= status_item_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: design/vehicle_telemetry_frame_deframer.sv
// Results are registered in the output queue before they are offered.
// Throughput: one byte per cycle unless stalled; the input stalls only while
// the output queue holds more than two results. The final byte of a buffer
// yields up to two results; the 4-entry queue drains one per unstalled cycle.
// Reset (asynchronous, active low) clears frame state, queue and handshakes.
// ----------------------------------------------------------------------------
// Vehicle telemetry frame deframer
// Splits received buffers into frames, passes body bytes through and closes
// each frame with a status covering start, XOR check and declared length.
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_telemetry_frame_deframer
  import vtfd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire vtfd_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output vtfd_out_t      out_data_o
);

  vtfd_push_t       push;
  vtfd_out_t        body_item;
  vtfd_out_t        status_item;
  logic             space_ok;
  logic [OQ_CW-1:0] level;

  // Per-byte frame tracking.
  vtfd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_data_i     (in_data_i),
    .space_ok_i    (space_ok),
    .push_o        (push),
    .body_item_o   (body_item),
    .status_item_o (status_item)
  );

  // Result queue towards the output channel.
  vtfd_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .body_item_i   (body_item),
    .status_item_i (status_item),
    .space_ok_o    (space_ok),
    .level_o       (level),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= OQ_CW'(OQ_DEPTH))
    else $error("output queue overfilled");

  // Results are pushed only when room for two remains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.body || push.status) |-> level <= OQ_CW'(OQ_DEPTH - 2))
    else $error("result pushed without room");

  // Body items always carry an ok status field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.frame_done) |-> out_data_o.frame_status == ST_OK)
    else $error("body item with nonzero status");

endmodule

`default_nettype wire
